// ===== rtl/core/sfrd_pkg.sv =====
`timescale 1ns / 1ps

package sfrd_pkg;

   localparam int BYTE_W   = 8;
   localparam int GROUP_W  = 32;
   localparam int RSP_DW   = 40;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd199;
   localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd101;

   typedef enum logic {
      CSR_HEADER = 1'b0,
      CSR_FOOTER = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_RECORD     = 2'd0,
      ST_HEADER_ERR = 2'd1,
      ST_FOOTER_ERR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_FOOTER,
      PH_BURST
   } phase_type;

   // result register load request from the parser
   typedef struct packed {
      logic       load;
      logic       from_ram;
      status_type status;
      logic       last;
   } rsp_load_type;

endpackage

// ===== rtl/core/sfrd_ram.sv =====
`timescale 1ns / 1ps

module sfrd_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sfrd_ctrl.sv =====
`timescale 1ns / 1ps

module sfrd_ctrl
   import sfrd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256,
   parameter int ADDR_W      = ((MAX_PAYLOAD / 4) > 1) ? $clog2(MAX_PAYLOAD / 4) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [BYTE_W-1:0]   req_tdata,
   output logic                req_tready,
   input  logic [BYTE_W-1:0]   header_value,
   input  logic [BYTE_W-1:0]   footer_value,
   input  logic                out_free,
   output logic                ram_wr_en,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic [GROUP_W-1:0]  ram_wr_data,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_rd_addr,
   output rsp_load_type        ld
);

   localparam int WORDS  = MAX_PAYLOAD / 4;
   localparam int GCNT_W = $clog2(WORDS + 1);

   phase_type             phase_ff, phase_in;
   logic [BYTE_W-1:0]     len_ff, len_in;
   logic [BYTE_W-1:0]     cnt_ff, cnt_in;
   logic [23:0]           asm_ff, asm_in;
   logic [GCNT_W-1:0]     groups_ff, groups_in;
   logic [GCNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                  pend_ff, pend_in;
   logic                  last_pend_ff, last_pend_in;
   logic                  acc;
   logic [GCNT_W-1:0]     kept_groups;
   logic [BYTE_W-1:0]     cnt_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      asm_ff       <= asm_in;
      groups_ff    <= groups_in;
      rd_idx_ff    <= rd_idx_in;
      last_pend_ff <= last_pend_in;
   end

   always_comb begin
      if ({1'b0, len_ff} >= 9'(MAX_PAYLOAD)) begin
         kept_groups = GCNT_W'(WORDS);
      end else begin
         kept_groups = GCNT_W'(len_ff[BYTE_W-1:2]);
      end
   end

   assign cnt_next    = cnt_ff + 8'd1;
   assign acc         = req_tvalid && req_tready;
   assign ram_wr_addr = cnt_ff[ADDR_W+1:2];
   assign ram_wr_data = {req_tdata, asm_ff};
   assign ram_rd_addr = rd_idx_ff[ADDR_W-1:0];

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      asm_in       = asm_ff;
      groups_in    = groups_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      last_pend_in = last_pend_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ld           = '{load: 1'b0, from_ram: 1'b0, status: ST_RECORD, last: 1'b1};

      case (phase_ff)
         PH_HUNT: begin
            req_tready = out_free;
            if (acc) begin
               if (req_tdata == header_value) begin
                  phase_in = PH_LENGTH;
               end else begin
                  ld.load   = 1'b1;
                  ld.status = ST_HEADER_ERR;
               end
            end
         end
         PH_LENGTH: begin
            req_tready = 1'b1;
            if (acc) begin
               len_in   = req_tdata;
               cnt_in   = '0;
               phase_in = (req_tdata == '0) ? PH_FOOTER : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            req_tready = 1'b1;
            if (acc) begin
               case (cnt_ff[1:0])
                  2'd0:    asm_in[7:0]   = req_tdata;
                  2'd1:    asm_in[15:8]  = req_tdata;
                  2'd2:    asm_in[23:16] = req_tdata;
                  default: ram_wr_en = ({1'b0, cnt_ff} < 9'(MAX_PAYLOAD));
               endcase
               cnt_in = cnt_next;
               if (cnt_next >= len_ff) begin
                  phase_in = PH_FOOTER;
               end
            end
         end
         PH_FOOTER: begin
            req_tready = out_free;
            if (acc) begin
               phase_in  = PH_HUNT;
               groups_in = kept_groups;
               rd_idx_in = '0;
               if (req_tdata != footer_value) begin
                  ld.load   = 1'b1;
                  ld.status = ST_FOOTER_ERR;
               end else if (kept_groups != '0) begin
                  phase_in = PH_BURST;
               end
            end
         end
         PH_BURST: begin
            if (pend_ff) begin
               ld.load     = 1'b1;
               ld.from_ram = 1'b1;
               ld.last     = last_pend_ff;
               if (last_pend_ff) begin
                  phase_in = PH_HUNT;
               end
            end else if (out_free && (rd_idx_ff != groups_ff)) begin
               ram_rd_en    = 1'b1;
               pend_in      = 1'b1;
               last_pend_in = (rd_idx_ff + GCNT_W'(1)) == groups_ff;
               rd_idx_in    = rd_idx_ff + GCNT_W'(1);
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

endmodule

// ===== rtl/core/serial_frame_record_deframer_unit.sv =====
`timescale 1ns / 1ps

// Serial frame deframer: takes one received byte per item and parses frames of
// header, length, payload and footer. Payload bytes are packed into 32-bit
// words held in a single-port-write, registered-read RAM of MAX_PAYLOAD/4
// entries. Header, length and payload bytes are taken one per cycle; header and
// footer bytes need the result register free. A matching footer with whole
// groups starts a burst that reads one word per record (RAM read, then result
// register load, each read waiting for a free result register), stalling the
// input until the last record loads. Bad header and bad footer bytes each give one
// error item with tlast set. Registers: index 0 header value, index 1 footer.
module serial_frame_record_deframer_unit
   import sfrd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [1:0] status, [9:2] motor_id,
                                          // [17:10] command_id, [33:18] value, rest 0
   output logic              rsp_tlast,   // last_record
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int WORDS  = MAX_PAYLOAD / 4;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [BYTE_W-1:0]  header_ff, header_in;
   logic [BYTE_W-1:0]  footer_ff, footer_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [GROUP_W-1:0] word_ff, word_in;
   logic               last_ff, last_in;
   logic               out_free;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [GROUP_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [GROUP_W-1:0] ram_rd_data;
   rsp_load_type       ld;

   sfrd_ctrl #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tdata    (req_tdata),
      .req_tready   (req_tready),
      .header_value (header_ff),
      .footer_value (footer_ff),
      .out_free     (out_free),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ld           (ld)
   );

   sfrd_ram #(
      .WIDTH  (GROUP_W),
      .DEPTH  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= HEADER_RESET;
         footer_ff    <= FOOTER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         footer_ff    <= footer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      word_ff   <= word_in;
      last_ff   <= last_in;
   end

   always_comb begin
      header_in = header_ff;
      footer_in = footer_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER: header_in = csr_wdata;
            CSR_FOOTER: footer_in = csr_wdata;
            default:    header_in = header_ff;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      if (ld.load) begin
         rsp_valid_in = 1'b1;
         status_in    = ld.status;
         last_in      = ld.last;
         word_in      = ld.from_ram ? ram_rd_data : '0;
      end
   end

   // word bytes in arrival order: motor, command, value high, value low
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, word_ff[23:16], word_ff[31:24], word_ff[15:8],
                        word_ff[7:0], status_ff};

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (ld.load && rsp_valid_ff) |-> rsp_tready)
      else $error("result register overwritten while held");

   a_burst_stall: assert property (@(posedge clock) disable iff (reset)
      ld.from_ram |-> !req_tready)
      else $error("input taken during record burst");

   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (ld.load && ld.from_ram))
      else $error("word read not followed by record load");

endmodule
